// ===== hdl/satd_pkg.sv =====
// ----------------------------------------------------------------------------
// satd_pkg
// Shared types, constants and row transform for the 4x4 Hadamard SATD unit.
// ----------------------------------------------------------------------------
package satd_pkg;

  localparam int BLOCK_ROWS_DEF = 32;
  localparam int LANES          = 8;
  localparam int PIX_W          = 8;
  localparam int ROW_W          = LANES * PIX_W;
  localparam int DIF_W          = PIX_W + 2;   // a - b, signed
  localparam int H_W            = 11;          // horizontal coefficient
  localparam int S_W            = 12;          // vertical pair sum / difference
  localparam int TILE_W         = 15;          // sum of 16 maxima over two tiles
  localparam int TOT_W          = 21;
  localparam int OUT_W          = 20;
  localparam int STORE_DEPTH    = 2;
  localparam int STORE_AW       = $clog2(STORE_DEPTH);

  // row position inside a group of four
  typedef enum logic [1:0] {
    POS_ROW0 = 2'd0,
    POS_ROW1 = 2'd1,
    POS_ROW2 = 2'd2,
    POS_ROW3 = 2'd3
  } pos_t;

  typedef logic [LANES-1:0][H_W-1:0] hrow_t;

  // per column: rows 0+1, rows 0-1 and row 2 of the current group
  typedef struct packed {
    logic signed [H_W-1:0] r2;
    logic signed [S_W-1:0] d;
    logic signed [S_W-1:0] s;
  } lane_t;

  typedef lane_t [LANES-1:0] word_t;

  localparam int WORD_W = $bits(word_t);

  // differences, then a 4-point hadamard over columns 0..3 and 4..7
  function automatic hrow_t row_transform(input logic [ROW_W-1:0] a,
                                          input logic [ROW_W-1:0] b);
    logic signed [DIF_W-1:0] d [LANES];
    logic signed [H_W-1:0]   s01;
    logic signed [H_W-1:0]   m01;
    logic signed [H_W-1:0]   s23;
    logic signed [H_W-1:0]   m23;
    hrow_t                   h;
    for (int c = 0; c < LANES; c++) begin
      d[c] = $signed({2'b00, a[c*PIX_W +: PIX_W]}) - $signed({2'b00, b[c*PIX_W +: PIX_W]});
    end
    for (int t = 0; t < 2; t++) begin
      s01 = d[4*t]   + d[4*t+1];
      m01 = d[4*t]   - d[4*t+1];
      s23 = d[4*t+2] + d[4*t+3];
      m23 = d[4*t+2] - d[4*t+3];
      h[4*t]   = s01 + s23;
      h[4*t+1] = s01 - s23;
      h[4*t+2] = m01 + m23;
      h[4*t+3] = m01 - m23;
    end
    return h;
  endfunction

  function automatic logic [S_W-1:0] mag(input logic signed [S_W-1:0] v);
    return v[S_W-1] ? S_W'(-v) : v;
  endfunction

endpackage

// ===== hdl/satd_ram.sv =====
// ----------------------------------------------------------------------------
// satd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module satd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/satd_tile_sum.sv =====
// ----------------------------------------------------------------------------
// satd_tile_sum
// Vertical hadamard stage of two 4x4 tiles and the sum of pair maxima.
// ----------------------------------------------------------------------------
module satd_tile_sum (
  input  satd_pkg::word_t             rd_word,
  input  satd_pkg::hrow_t             h_row,
  output logic [satd_pkg::TILE_W-1:0] tile_sum
);

  logic signed [satd_pkg::S_W-1:0] t_p [satd_pkg::LANES];
  logic signed [satd_pkg::S_W-1:0] t_m [satd_pkg::LANES];
  logic [satd_pkg::S_W-1:0]        mx_p [satd_pkg::LANES];
  logic [satd_pkg::S_W-1:0]        mx_m [satd_pkg::LANES];
  logic [satd_pkg::S_W-1:0]        a_s, a_d, a_tp, a_tm;
  logic [satd_pkg::S_W:0]          lvl0 [satd_pkg::LANES];
  logic [satd_pkg::S_W+1:0]        lvl1 [satd_pkg::LANES/2];
  logic [satd_pkg::S_W+2:0]        lvl2 [satd_pkg::LANES/4];

  always_comb begin
    for (int k = 0; k < satd_pkg::LANES; k++) begin
      t_p[k] = rd_word[k].r2 + $signed(h_row[k]);
      t_m[k] = rd_word[k].r2 - $signed(h_row[k]);
      a_s    = satd_pkg::mag(rd_word[k].s);
      a_d    = satd_pkg::mag(rd_word[k].d);
      a_tp   = satd_pkg::mag(t_p[k]);
      a_tm   = satd_pkg::mag(t_m[k]);
      mx_p[k] = (a_s > a_tp) ? a_s : a_tp;
      mx_m[k] = (a_d > a_tm) ? a_d : a_tm;
      lvl0[k] = {1'b0, mx_p[k]} + {1'b0, mx_m[k]};
    end
    for (int k = 0; k < satd_pkg::LANES/2; k++) begin
      lvl1[k] = {1'b0, lvl0[2*k]} + {1'b0, lvl0[2*k+1]};
    end
    for (int k = 0; k < satd_pkg::LANES/4; k++) begin
      lvl2[k] = {1'b0, lvl1[2*k]} + {1'b0, lvl1[2*k+1]};
    end
    tile_sum = satd_pkg::TILE_W'({1'b0, lvl2[0]} + {1'b0, lvl2[1]});
  end

endmodule

// ===== hdl/satd_hadamard_4x4_8x32_unit.sv =====
// ----------------------------------------------------------------------------
// satd_hadamard_4x4_8x32_unit
// SATD of an 8-column block pair over 4x4 hadamard tiles, one row per transfer.
// ----------------------------------------------------------------------------
// Takes one row of eight pixel pairs per cycle and emits the raw SATD total
// of the block after the transfer of its last row (BLOCK_ROWS rows per block).
// The horizontal transform is done on entry; per-column partial vertical sums
// live in a small row-store RAM that is read on the input transfer and written
// back from the stage-1 register, with a forwarding register covering
// back-to-back rows of the same group. Sustained rate is one row per clock;
// the block total is registered after stage 1. Rows after the last full
// group of four in a block add nothing. The input only stalls when a finished
// total is still waiting on the output and the next total is ready.
module satd_hadamard_4x4_8x32_unit #(
  parameter int BLOCK_ROWS = satd_pkg::BLOCK_ROWS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [satd_pkg::ROW_W-1:0] in_row_a,
  input  logic [satd_pkg::ROW_W-1:0] in_row_b,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [satd_pkg::OUT_W-1:0] out_satd_total
);

  localparam int CNT_W = $clog2(BLOCK_ROWS);

  logic                          accept;
  logic                          s1_go;
  logic [CNT_W-1:0]              cnt_r, cnt_nxt;
  logic [satd_pkg::STORE_AW-1:0] grp_r, grp_nxt;
  logic                          in_last;
  satd_pkg::pos_t                in_pos;

  logic                          s1_v_r, s1_v_nxt;
  satd_pkg::hrow_t               s1_h_r;
  satd_pkg::pos_t                s1_pos_r;
  logic                          s1_last_r;
  logic [satd_pkg::STORE_AW-1:0] s1_addr_r;
  logic                          fwd_sel_r;
  satd_pkg::word_t               fwd_r;

  logic [satd_pkg::WORD_W-1:0]   ram_rdata;
  satd_pkg::word_t               rd_word, wr_word;
  logic                          ram_we;
  logic [satd_pkg::TILE_W-1:0]   tile_sum;
  logic [satd_pkg::TOT_W-1:0]    total_r, total_nxt, total_sum;
  logic                          out_v_r, out_v_nxt;
  logic [satd_pkg::OUT_W-1:0]    out_total_r;

  assign s1_go    = !s1_last_r || !out_v_r || !out_stall;
  assign in_stall = s1_v_r && !s1_go;
  assign accept   = in_valid && !in_stall;
  assign ram_we   = s1_v_r && s1_go;

  assign in_pos   = satd_pkg::pos_t'(cnt_r[1:0]);
  assign in_last  = (cnt_r == CNT_W'(BLOCK_ROWS - 1));
  assign cnt_nxt  = in_last ? '0 : cnt_r + CNT_W'(1);
  assign grp_nxt  = (in_pos == satd_pkg::POS_ROW3) ? grp_r + satd_pkg::STORE_AW'(1) : grp_r;

  satd_ram #(
    .WIDTH (satd_pkg::WORD_W),
    .DEPTH (satd_pkg::STORE_DEPTH)
  ) u_row_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s1_addr_r),
    .wdata (wr_word),
    .re    (accept),
    .raddr (grp_r),
    .rdata (ram_rdata)
  );

  // write-back of the previous row lands on the same edge as this read
  assign rd_word = fwd_sel_r ? fwd_r : satd_pkg::word_t'(ram_rdata);

  always_comb begin
    wr_word = rd_word;
    for (int k = 0; k < satd_pkg::LANES; k++) begin
      unique case (s1_pos_r)
        satd_pkg::POS_ROW0: begin
          wr_word[k].s  = satd_pkg::S_W'($signed(s1_h_r[k]));
          wr_word[k].d  = satd_pkg::S_W'($signed(s1_h_r[k]));
          wr_word[k].r2 = $signed(s1_h_r[k]);
        end
        satd_pkg::POS_ROW1: begin
          wr_word[k].s = rd_word[k].s + $signed(s1_h_r[k]);
          wr_word[k].d = rd_word[k].d - $signed(s1_h_r[k]);
        end
        satd_pkg::POS_ROW2: begin
          wr_word[k].r2 = $signed(s1_h_r[k]);
        end
        satd_pkg::POS_ROW3: begin
          wr_word[k] = rd_word[k];
        end
        default: begin
          wr_word[k] = rd_word[k];
        end
      endcase
    end
  end

  satd_tile_sum u_tile_sum (
    .rd_word  (rd_word),
    .h_row    (s1_h_r),
    .tile_sum (tile_sum)
  );

  assign total_sum = (s1_pos_r == satd_pkg::POS_ROW3)
                   ? total_r + satd_pkg::TOT_W'(tile_sum) : total_r;

  always_comb begin
    total_nxt = total_r;
    out_v_nxt = out_v_r;
    s1_v_nxt  = s1_v_r;
    if (ram_we) begin
      total_nxt = s1_last_r ? '0 : total_sum;
      s1_v_nxt  = 1'b0;
    end
    if (accept) begin
      s1_v_nxt = 1'b1;
    end
    priority if (ram_we && s1_last_r) begin
      out_v_nxt = 1'b1;
    end else if (!out_stall) begin
      out_v_nxt = 1'b0;
    end else begin
      out_v_nxt = out_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r     <= '0;
      grp_r     <= '0;
      s1_v_r    <= 1'b0;
      fwd_sel_r <= 1'b0;
      total_r   <= '0;
      out_v_r   <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      total_r <= total_nxt;
      out_v_r <= out_v_nxt;
      if (accept) begin
        cnt_r     <= cnt_nxt;
        grp_r     <= grp_nxt;
        fwd_sel_r <= ram_we && (s1_addr_r == grp_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_h_r    <= satd_pkg::row_transform(in_row_a, in_row_b);
      s1_pos_r  <= in_pos;
      s1_last_r <= in_last;
      s1_addr_r <= grp_r;
      fwd_r     <= wr_word;
    end
    if (ram_we && s1_last_r) begin
      out_total_r <= total_sum[satd_pkg::OUT_W-1:0];
    end
  end

  assign out_valid      = out_v_r;
  assign out_satd_total = out_total_r;

endmodule

// ===== hdl/satd_chk.sv =====
// ----------------------------------------------------------------------------
// satd_chk
// Port-level checks for the SATD unit, bound to the top level.
// ----------------------------------------------------------------------------
module satd_chk (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [satd_pkg::OUT_W-1:0] out_satd_total
);

  // a held result keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_satd_total))
    else $error("result changed while stalled");

  // the input only backs up behind a waiting result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty output");

  // a fresh result follows a row transfer through stage 1 and the output register
  a_rise_after_row: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
    else $error("result without a preceding row transfer");

  // total never exceeds 1044480
  a_total_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_satd_total <= satd_pkg::OUT_W'(1044480))
    else $error("total out of range");

endmodule

bind satd_hadamard_4x4_8x32_unit satd_chk u_satd_chk (.*);
